>>> hw/rtl/nearest_calibration_z_search_assert.svh
// Assertion macros shared by the nearest calibration z search RTL.
`ifndef NEAREST_CALIBRATION_Z_SEARCH_ASSERT_SVH
`define NEAREST_CALIBRATION_Z_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clk_i outside reset.
`define NCZ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nearest_calibration_z_search: assertion failed");

// Next-cycle implication, sampled on the rising edge of clk_i outside reset.
`define NCZ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nearest_calibration_z_search: assertion failed");

`endif

>>> hw/rtl/ncz_pkg.sv
// Package with the types, constants and codes of the nearest calibration z search.
`timescale 1ns / 1ps
package ncz_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  localparam int WidthW  = 16;
  localparam int CutoffW = 33;
  localparam int ZBaseW  = 15;
  localparam int UsedW   = 11;
  localparam int ZValW   = 16;
  localparam int DistW   = 33;
  localparam int SqW     = 2 * WidthW;

  // Request codes.
  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Register slots on the configuration port (8-byte spacing).
  localparam int          PaddrW    = 5;
  localparam int          PdataW    = 64;
  localparam logic [1:0]  RegCutoff = 2'd0;
  localparam logic [1:0]  RegZBase  = 2'd1;
  localparam logic [1:0]  RegUsed   = 2'd2;

  localparam logic [CutoffW-1:0] CutoffReset = '0;
  localparam logic [ZBaseW-1:0]  ZBaseReset  = -15'sd500;
  localparam logic [UsedW-1:0]   UsedReset   = 11'd1000;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StResult
  } ncz_state_e;

  typedef struct packed {
    logic load;
    logic init;
    logic issue;
    logic emit;
  } ncz_cmd_t;

  typedef struct packed {
    logic last_addr;
    logic pipe_busy;
  } ncz_status_t;

endpackage

>>> hw/rtl/ncz_ram.sv
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
module ncz_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ncz_ctrl.sv
// Controller state machine sequencing loads and table scans.
`timescale 1ns / 1ps
module ncz_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                opcode_i,
  input  ncz_pkg::ncz_status_t status_i,
  output ncz_pkg::ncz_cmd_t    cmd_o,
  output logic                busy_o
);
  import ncz_pkg::*;

  ncz_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i && (opcode_i == OpQuery)) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (status_i.last_addr) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!status_i.pipe_busy) begin
          state_d = StResult;
        end
      end
      StResult: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i && (opcode_i == OpLoad);
        cmd_o.init = start_i && (opcode_i == OpQuery);
      end
      StScan:   cmd_o.issue = 1'b1;
      StDrain:  cmd_o = '0;
      StResult: cmd_o.emit = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

endmodule

>>> hw/rtl/ncz_dp.sv
// Datapath: calibration table, distance pipeline, running minimum and result.
`timescale 1ns / 1ps
module ncz_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ncz_pkg::ncz_cmd_t             cmd_i,
  output ncz_pkg::ncz_status_t          status_o,
  input  logic [9:0]                    entry_index_i,
  input  logic [ncz_pkg::WidthW-1:0]    width_x_i,
  input  logic [ncz_pkg::WidthW-1:0]    width_y_i,
  input  logic [ncz_pkg::CutoffW-1:0]   cutoff_i,
  input  logic [ncz_pkg::ZBaseW-1:0]    z_base_i,
  input  logic [ncz_pkg::UsedW-1:0]     entries_used_i,
  output logic                          done_o,
  output logic signed [ncz_pkg::ZValW-1:0] z_value_o,
  output logic                          rejected_o,
  output logic [ncz_pkg::DistW-1:0]     best_distance_o
);
  import ncz_pkg::*;

  // Table write port.
  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [2*WidthW-1:0]   rdata;

  assign we    = cmd_i.load && (32'(entry_index_i) < 32'(TableDepth));
  assign waddr = IdxW'(entry_index_i);

  // Query operands and scan counter.
  logic [WidthW-1:0] wx_q, wy_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   addr_q;

  always_comb begin
    if (entries_used_i == '0) begin
      count_d = CntW'(1);
    end else if (32'(entries_used_i) > 32'(TableDepth)) begin
      count_d = CntW'(TableDepth);
    end else begin
      count_d = CntW'(entries_used_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      wx_q    <= width_x_i;
      wy_q    <= width_y_i;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.init) begin
      addr_q <= '0;
    end else if (cmd_i.issue) begin
      addr_q <= addr_q + IdxW'(1);
    end
  end

  ncz_ram #(
    .Width (2 * WidthW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({width_x_i, width_y_i}),
    .re_i    (cmd_i.issue),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // Stage 1 is the RAM read, stage 2 the absolute differences, stage 3 the
  // squares and stage 4 their sum, which then meets the running minimum.
  logic                v1_q, v2_q, v3_q, v4_q;
  logic [IdxW-1:0]     i1_q, i2_q, i3_q, i4_q;
  logic [WidthW-1:0]   dx_q, dy_q, dx_d, dy_d;
  logic [SqW-1:0]      sqx_q, sqy_q;
  logic [DistW-1:0]    sum_q;

  logic [WidthW-1:0] tx, ty;
  assign tx = rdata[2*WidthW-1:WidthW];
  assign ty = rdata[WidthW-1:0];

  assign dx_d = (wx_q >= tx) ? (wx_q - tx) : (tx - wx_q);
  assign dy_d = (wy_q >= ty) ? (wy_q - ty) : (ty - wy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q  <= addr_q;
    i2_q  <= i1_q;
    i3_q  <= i2_q;
    i4_q  <= i3_q;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    sqx_q <= dx_q * dx_q;
    sqy_q <= dy_q * dy_q;
    sum_q <= DistW'(sqx_q) + DistW'(sqy_q);
  end

  // Running minimum; a strict compare keeps the lowest index on ties.
  logic             best_valid_q;
  logic [DistW-1:0] best_d_q;
  logic [IdxW-1:0]  best_i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
    end else if (cmd_i.init) begin
      best_valid_q <= 1'b0;
    end else if (v4_q) begin
      best_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q && (!best_valid_q || (sum_q < best_d_q))) begin
      best_d_q <= sum_q;
      best_i_q <= i4_q;
    end
  end

  assign status_o.last_addr = (CntW'(addr_q) == (count_q - CntW'(1)));
  assign status_o.pipe_busy = v1_q || v2_q || v3_q || v4_q;

  // Result register.
  logic              done_q;
  logic [ZValW-1:0]  z_q, z_d, zb_ext;
  logic              rej_q, rej_d;
  logic [DistW-1:0]  bd_q;

  assign zb_ext = {z_base_i[ZBaseW-1], z_base_i};
  assign rej_d  = (best_d_q > cutoff_i);
  assign z_d    = rej_d ? (zb_ext - ZValW'(1)) : (zb_ext + ZValW'(best_i_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      z_q   <= z_d;
      rej_q <= rej_d;
      bd_q  <= best_d_q;
    end
  end

  assign done_o          = done_q;
  assign z_value_o       = signed'(z_q);
  assign rejected_o      = rej_q;
  assign best_distance_o = bd_q;

endmodule

>>> hw/rtl/nearest_calibration_z_search.sv
// Top level of the nearest calibration z search: register port and block wiring.
//
// Requests enter on start with opcode, entry_index, width_x and width_y and
// are taken on a rising edge where start is high and busy is low.
// A load request writes one table entry in that cycle; busy stays low, so
// loads may follow one another every cycle and produce no result.
// A query request scans table entries 0 to entries_used - 1 (at least one,
// at most the table depth), reading one entry per cycle from the single
// table RAM, through a four-stage distance pipeline and a running minimum.
// busy is high from the cycle after the query is taken until the result is
// formed; done_o pulses for one cycle with z_value_o, rejected_o and
// best_distance_o, which the receiver must take then, as it cannot stall.
// A query runs through the scan, the drain of the pipeline and the result state;
// the next request may be taken in the cycle done_o is high.
// Registers sit on the APB port at byte addresses 0 (distance cutoff),
// 8 (z base) and 16 (entries used), 64-bit data, pready always high; the
// user must write them only while busy is low; the block does not enforce it.
// Reset clears the controller and loads the register defaults; the table
// is not cleared, and each entry must be loaded before a query reads it.
`timescale 1ns / 1ps
`include "nearest_calibration_z_search_assert.svh"
module nearest_calibration_z_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode_i,
  input  logic [9:0]                        entry_index_i,
  input  logic [ncz_pkg::WidthW-1:0]        width_x_i,
  input  logic [ncz_pkg::WidthW-1:0]        width_y_i,
  output logic                              done_o,
  output logic signed [ncz_pkg::ZValW-1:0]  z_value_o,
  output logic                              rejected_o,
  output logic [ncz_pkg::DistW-1:0]         best_distance_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ncz_pkg::PaddrW-1:0]        paddr,
  input  logic [ncz_pkg::PdataW-1:0]        pwdata,
  output logic [ncz_pkg::PdataW-1:0]        prdata,
  output logic                              pready
);
  import ncz_pkg::*;

  logic [CutoffW-1:0] cutoff_q;
  logic [ZBaseW-1:0]  z_base_q;
  logic [UsedW-1:0]   used_q;
  logic               wr_en;
  logic [1:0]         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CutoffReset;
      z_base_q <= ZBaseReset;
      used_q   <= UsedReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegCutoff: cutoff_q <= pwdata[CutoffW-1:0];
        RegZBase:  z_base_q <= pwdata[ZBaseW-1:0];
        RegUsed:   used_q   <= pwdata[UsedW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegCutoff: prdata = PdataW'(cutoff_q);
      RegZBase:  prdata = PdataW'(z_base_q);
      RegUsed:   prdata = PdataW'(used_q);
      default:   prdata = '0;
    endcase
  end

  ncz_cmd_t    cmd;
  ncz_status_t status;
  logic        start_acc;

  assign start_acc = start && !busy;

  ncz_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  ncz_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .entry_index_i   (entry_index_i),
    .width_x_i       (width_x_i),
    .width_y_i       (width_y_i),
    .cutoff_i        (cutoff_q),
    .z_base_i        (z_base_q),
    .entries_used_i  (used_q),
    .done_o          (done_o),
    .z_value_o       (z_value_o),
    .rejected_o      (rejected_o),
    .best_distance_o (best_distance_o)
  );

  `NCZ_ASSERT_NXT(a_query_goes_busy, start_acc && (opcode_i == OpQuery), busy)
  `NCZ_ASSERT_NXT(a_load_stays_idle, start_acc && (opcode_i == OpLoad), !busy)
  `NCZ_ASSERT_IMP(a_done_when_idle, done_o, !busy)
  `NCZ_ASSERT_NXT(a_done_single_pulse, done_o, !done_o)

endmodule
